/* hdl/slab_pkg.sv */
package slab_pkg;
	localparam int PAGE_BYTES  = 4096;
	localparam int NUM_PAGES   = 64;
	localparam int MAX_OBJECTS = 256;
	localparam int PAGE_W      = $clog2(NUM_PAGES);
	localparam int LINK_W      = PAGE_W + 1;
	localparam int SLOT_W      = $clog2(MAX_OBJECTS);
	localparam int OFF_W       = $clog2(PAGE_BYTES);
	localparam int ADDR_W      = 18;
	localparam int WORD_W      = 64;
	localparam int WPP         = (MAX_OBJECTS + WORD_W - 1) / WORD_W;
	localparam int WSEL_W      = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int BM_DEPTH    = NUM_PAGES * WPP;
	localparam int BM_AW       = $clog2(BM_DEPTH);
	localparam int USE_W       = SLOT_W + 1;
	localparam logic [LINK_W-1:0] NIL = '1;

	typedef enum logic [1:0] {
		CLS_UNUSED  = 2'd0,
		CLS_EMPTY   = 2'd1,
		CLS_PARTIAL = 2'd2,
		CLS_FULL    = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_BAD_FREE  = 2'd2
	} status_t;

	localparam logic CFG_OBJECT_SIZE = 1'b0;
	localparam logic CFG_OBJECTS     = 1'b1;
endpackage

/* hdl/slab_object_allocator.sv */
// Slab allocator over 64 pages of 4096 bytes. Pulse start while busy is low; the
// block then runs for a variable number of cycles and pulses done for one cycle
// with alloc_address and status, which must be taken in that cycle: the receiver
// cannot stall. An allocate picks a page, scans the 64-bit bitmap words of that
// page one by one (one to four words), forms slot * size by shift-add and moves
// the page between lists when its class changes. A free runs a one-bit-a-cycle
// divide of the in-page offset less the header by object_size. Errors end early,
// straight after the first check, for an exhausted pool, a page not in use or an
// offset in the header. Busy falls as done rises. After reset a clearing pass
// over all 256 bitmap words zeroes the bitmap memory; busy stays high meanwhile.
// Configuration writes are taken while busy is low.
module slab_object_allocator
	import slab_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [ADDR_W-1:0] object_address,
	output logic              done,
	output logic [ADDR_W-1:0] alloc_address,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [11:0]       cfg_data
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_APICK, S_ASCAN, S_AWAIT, S_AFOUND, S_AMUL,
		S_FCHK, S_FDIV, S_FREAD, S_FWAIT, S_FHOLD, S_FBIT, S_RECLS, S_RLINK,
		S_RPREV, S_DONE
	} state_t;

	state_t state_q;
	logic [11:0] osize_q;
	logic [8:0]  ocount_q;
	logic        cfg_idx_ok;

	logic [LINK_W-1:0] head_q  [3];
	logic [LINK_W-1:0] fresh_q;

	logic [ADDR_W-1:0] addr_q;
	logic [PAGE_W-1:0] page_q;
	logic [WSEL_W:0]   word_q;
	logic [SLOT_W:0]   slot_q;
	logic [OFF_W-1:0]  rem_q;
	logic [OFF_W-1:0]  quo_q;
	logic [4:0]        cnt_q;
	logic [ADDR_W-1:0] acc_q;
	logic [BM_AW-1:0]  clr_q;
	logic              use_inc_q;
	logic [USE_W-1:0]  use_q;
	cls_t              ocls_q;
	logic [LINK_W-1:0] nx_q, pv_q;

	logic              bm_we;
	logic [BM_AW-1:0]  bm_waddr, bm_raddr;
	logic [WORD_W-1:0] bm_wdata, bm_rdata, word_hold_q;

	slab_ram #(.WIDTH(WORD_W), .DEPTH(BM_DEPTH)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	// per-page usage, links and list class
	logic              use_we, nxt_we, prv_we, cls_we;
	logic [PAGE_W-1:0] use_wa, nxt_wa, prv_wa, cls_wa;
	logic [USE_W-1:0]  use_wd, use_rd;
	logic [LINK_W-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;
	logic [1:0]        cls_wd, cls_rd;

	slab_ram #(.WIDTH(USE_W), .DEPTH(NUM_PAGES)) u_usage (
		.clk(clk), .we(use_we), .waddr(use_wa), .wdata(use_wd),
		.raddr(page_q), .rdata(use_rd)
	);
	slab_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(page_q), .rdata(nxt_rd)
	);
	slab_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(page_q), .rdata(prv_rd)
	);
	slab_ram #(.WIDTH(2), .DEPTH(NUM_PAGES)) u_class (
		.clk(clk), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd),
		.raddr(page_q), .rdata(cls_rd)
	);

	// effective register values
	logic [SLOT_W:0]  ecount;
	logic [11:0]      esize;
	logic [OFF_W-1:0] hdr;
	always_comb begin
		if (ocount_q == '0) ecount = (SLOT_W+1)'(1);
		else if ({3'b0, ocount_q} > 12'(MAX_OBJECTS)) ecount = (SLOT_W+1)'(MAX_OBJECTS);
		else ecount = (SLOT_W+1)'(ocount_q);
		esize = (osize_q == '0) ? 12'd1 : osize_q;
		hdr = OFF_W'(16) + OFF_W'((ecount + (SLOT_W+1)'(7)) >> 3);
	end

	// first zero in the word among valid slots
	logic [WORD_W-1:0] masked;
	logic              fz_hit;
	logic [5:0]        fz_idx;
	always_comb begin
		for (int i = 0; i < WORD_W; i++)
			masked[i] = word_hold_q[i] |
				((SLOT_W+2)'({word_q[WSEL_W-1:0], 6'(i)}) >= (SLOT_W+2)'(ecount));
		fz_hit = ~&masked;
		fz_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--)
			if (!masked[i]) fz_idx = 6'(i);
	end

	// target class after the usage change
	cls_t       new_cls;
	logic [1:0] new_hidx, old_hidx;
	always_comb begin
		if (use_q == '0) new_cls = CLS_EMPTY;
		else if (use_q >= USE_W'(ecount)) new_cls = CLS_FULL;
		else new_cls = CLS_PARTIAL;
	end
	assign new_hidx = new_cls - 2'd1;
	assign old_hidx = ocls_q - 2'd1;

	logic fresh_take;
	logic free_ok;
	assign fresh_take = (head_q[CLS_PARTIAL-1] == NIL) && (head_q[CLS_EMPTY-1] == NIL)
		&& (fresh_q < LINK_W'(NUM_PAGES));
	assign free_ok = word_hold_q[slot_q[5:0]] && (use_rd != '0);

	logic [PAGE_W-1:0] in_page;
	logic [OFF_W-1:0]  in_off;
	assign in_page = PAGE_W'(addr_q >> OFF_W);
	assign in_off  = addr_q[OFF_W-1:0];
	assign cfg_idx_ok = 1'b1;
	assign cfg_ready = cfg_idx_ok & ~busy;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		bm_we = 1'b0;
		bm_waddr = {page_q, word_q[WSEL_W-1:0]};
		bm_wdata = word_hold_q;
		bm_raddr = {page_q, word_q[WSEL_W-1:0]};
		unique case (state_q)
			S_CLEAR: begin
				bm_we = 1'b1; bm_waddr = clr_q; bm_wdata = '0;
			end
			S_AFOUND: begin
				bm_we = 1'b1; bm_wdata = word_hold_q | (WORD_W'(1) << fz_idx);
			end
			S_FBIT: begin
				bm_we = free_ok;
				bm_wdata = word_hold_q & ~(WORD_W'(1) << slot_q[5:0]);
			end
			default: ;
		endcase
	end

	always_comb begin
		use_we = 1'b0; use_wa = page_q; use_wd = use_rd;
		nxt_we = 1'b0; nxt_wa = page_q; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = page_q; prv_wd = NIL;
		cls_we = 1'b0; cls_wa = page_q; cls_wd = new_cls;
		unique case (state_q)
			S_APICK: if (fresh_take) begin
				// fresh page starts empty and alone on the empty list
				use_we = 1'b1; use_wa = PAGE_W'(fresh_q); use_wd = '0;
				nxt_we = 1'b1; nxt_wa = PAGE_W'(fresh_q);
				prv_we = 1'b1; prv_wa = PAGE_W'(fresh_q);
				cls_we = 1'b1; cls_wa = PAGE_W'(fresh_q); cls_wd = CLS_EMPTY;
			end
			S_AFOUND: if (fz_hit) begin
				use_we = 1'b1; use_wd = use_rd + 1'b1;
			end
			S_FBIT: if (free_ok) begin
				use_we = 1'b1; use_wd = use_rd - 1'b1;
			end
			S_RECLS: if (new_cls != ocls_q) begin
				nxt_we = (pv_q != NIL); nxt_wa = PAGE_W'(pv_q); nxt_wd = nx_q;
				prv_we = (nx_q != NIL); prv_wa = PAGE_W'(nx_q); prv_wd = pv_q;
			end
			S_RLINK: begin
				nxt_we = 1'b1; nxt_wd = head_q[new_hidx];
				prv_we = (head_q[new_hidx] != NIL);
				prv_wa = PAGE_W'(head_q[new_hidx]);
				prv_wd = LINK_W'(page_q);
				cls_we = 1'b1;
			end
			S_RPREV: prv_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			osize_q <= 12'd16;
			ocount_q <= 9'd226;
			for (int c = 0; c < 3; c++) head_q[c] <= NIL;
			fresh_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
			alloc_address <= '0;
			status <= ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_OBJECT_SIZE: osize_q <= cfg_data;
					CFG_OBJECTS: ocount_q <= cfg_data[8:0];
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BM_AW'(BM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					addr_q <= object_address;
					state_q <= mode ? S_FCHK : S_APICK;
				end
				S_APICK: begin
					word_q <= '0;
					if (head_q[CLS_PARTIAL-1] != NIL) begin
						page_q <= PAGE_W'(head_q[CLS_PARTIAL-1]); state_q <= S_ASCAN;
					end else if (head_q[CLS_EMPTY-1] != NIL) begin
						page_q <= PAGE_W'(head_q[CLS_EMPTY-1]); state_q <= S_ASCAN;
					end else if (fresh_take) begin
						// take a fresh page onto the empty list
						page_q <= PAGE_W'(fresh_q);
						fresh_q <= fresh_q + 1'b1;
						head_q[CLS_EMPTY-1] <= fresh_q;
						state_q <= S_ASCAN;
					end else begin
						alloc_address <= '0; status <= ST_EXHAUSTED; state_q <= S_DONE;
					end
				end
				S_ASCAN: state_q <= S_AWAIT;
				S_AWAIT: begin
					word_hold_q <= bm_rdata;
					state_q <= S_AFOUND;
				end
				S_AFOUND: begin
					if (fz_hit) begin
						slot_q <= (SLOT_W+1)'({word_q[WSEL_W-1:0], fz_idx});
						use_q <= use_rd + 1'b1;
						ocls_q <= cls_t'(cls_rd);
						nx_q <= nxt_rd;
						pv_q <= prv_rd;
						acc_q <= ADDR_W'({page_q, OFF_W'(0)}) + ADDR_W'(hdr);
						cnt_q <= '0;
						state_q <= S_AMUL;
					end else if ((SLOT_W+2)'({word_q + 1'b1, 6'd0}) >= (SLOT_W+2)'(ecount)) begin
						alloc_address <= '0; status <= ST_EXHAUSTED; state_q <= S_DONE;
					end else begin
						word_q <= word_q + 1'b1; state_q <= S_ASCAN;
					end
				end
				S_AMUL: begin
					// shift-add slot * size, one slot bit a cycle
					if (slot_q[cnt_q[3:0]])
						acc_q <= acc_q + ADDR_W'({esize, OFF_W'(0)} >> (OFF_W - cnt_q));
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(SLOT_W)) begin
						use_inc_q <= 1'b1; state_q <= S_RECLS;
					end
				end
				S_FCHK: begin
					page_q <= in_page;
					if (LINK_W'(in_page) >= fresh_q || in_off < hdr) begin
						status <= ST_BAD_FREE; alloc_address <= '0; state_q <= S_DONE;
					end else begin
						rem_q <= in_off - hdr; quo_q <= '0; cnt_q <= '0;
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					// restoring divide, quotient bit per cycle, msb first
					if ({12'b0, rem_q} >= ({12'b0, OFF_W'(esize)} << (OFF_W-1-cnt_q))
						&& ({12'b0, esize} << (OFF_W-1-cnt_q)) <= {12'b0, rem_q}) begin
						rem_q <= rem_q - OFF_W'({12'b0, esize} << (OFF_W-1-cnt_q));
						quo_q <= quo_q | (OFF_W'(1) << (OFF_W-1-cnt_q));
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(OFF_W-1)) state_q <= S_FREAD;
				end
				S_FREAD: begin
					if (quo_q >= OFF_W'(MAX_OBJECTS)) begin
						status <= ST_BAD_FREE; alloc_address <= '0; state_q <= S_DONE;
					end else begin
						slot_q <= (SLOT_W+1)'(quo_q);
						word_q <= (WSEL_W+1)'(quo_q >> 6);
						state_q <= S_FWAIT;
					end
				end
				S_FWAIT: state_q <= S_FHOLD;
				S_FHOLD: begin
					word_hold_q <= bm_rdata;
					state_q <= S_FBIT;
				end
				S_FBIT: begin
					if (!free_ok) begin
						status <= ST_BAD_FREE; alloc_address <= '0; state_q <= S_DONE;
					end else begin
						use_q <= use_rd - 1'b1;
						ocls_q <= cls_t'(cls_rd);
						nx_q <= nxt_rd;
						pv_q <= prv_rd;
						use_inc_q <= 1'b0; state_q <= S_RECLS;
					end
				end
				S_RECLS: begin
					if (new_cls != ocls_q) begin
						// unlink, then push at head of new list
						if (pv_q == NIL) head_q[old_hidx] <= nx_q;
						state_q <= S_RLINK;
					end else begin
						status <= ST_OK;
						alloc_address <= use_inc_q ? acc_q : '0;
						state_q <= S_DONE;
					end
				end
				S_RLINK: begin
					head_q[new_hidx] <= LINK_W'(page_q);
					state_q <= S_RPREV;
				end
				S_RPREV: begin
					status <= ST_OK;
					alloc_address <= use_inc_q ? acc_q : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/slab_ram.sv */
module slab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* hdl/slab_checker.sv */
module slab_checker
	import slab_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [ADDR_W-1:0] alloc_address,
	input logic [1:0]        status
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a transaction");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> alloc_address == '0) else $error("address on error");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_EXHAUSTED || status == ST_BAD_FREE))
		else $error("bad status");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
endmodule

bind slab_object_allocator slab_checker u_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.alloc_address(alloc_address), .status(status)
);
